// File: hdl/dmdup_pkg.sv
// Shared types, widths, register codes and helper functions of the pixel upscaler.
// No dependencies; compiled first.
package dmdup_pkg;

	// Block size per source pixel; fixed.
	localparam int SCALE = 5;
	localparam int SUB_W = $clog2(SCALE);

	// Field widths.
	localparam int ZI_W    = 6;
	localparam int PIX_W   = 24;
	localparam int X_W     = 10;
	localparam int Y_W     = 8;
	localparam int COLOR_W = 16;

	// Defaults of the top-level parameters.
	localparam int ZONE_COLS_DEF    = 16;
	localparam int ZONE_ROWS_DEF    = 8;
	localparam int ZONES_ACROSS_DEF = 8;
	localparam int JOB_DEPTH_DEF    = 2;

	// Configuration port.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SCALING_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_FORMAT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = CFG_IDX_W'(3);

	typedef enum logic [1:0] {
		MODE_FULL   = 2'd0,
		MODE_CENTER = 2'd1,
		MODE_BORDER = 2'd2,
		MODE_DIAG   = 2'd3
	} mode_t;

	typedef enum logic {
		FMT_RGB888 = 1'b0,
		FMT_RGB565 = 1'b1
	} fmt_t;

	typedef struct packed {
		mode_t              mode;
		fmt_t               fmt;
		logic [X_W-1:0]     x_off;
		logic [Y_W-1:0]     y_off;
	} cfg_t;

	// One source pixel, ready for expansion.
	typedef struct packed {
		logic [X_W-1:0]     base_x;
		logic [Y_W-1:0]     base_y;
		logic [COLOR_W-1:0] color;
		logic               zone_end;
	} job_t;

	// RGB888 truncates to 5:6:5; RGB565 takes the low half word.
	function automatic logic [COLOR_W-1:0] to_rgb565(input logic [PIX_W-1:0] px,
		input fmt_t fmt);
		logic [COLOR_W-1:0] c;
		if (fmt == FMT_RGB565) begin
			c = px[15:0];
		end else begin
			c = {px[23:19], px[15:10], px[7:3]};
		end
		return c;
	endfunction

	// Dot mask: 1 where the sub-pixel takes the color.
	function automatic logic sub_lit(input mode_t mode, input logic [SUB_W-1:0] i,
		input logic [SUB_W-1:0] j);
		logic r;
		unique case (mode)
			MODE_CENTER: r = (i >= SUB_W'(1)) && (i <= SUB_W'(3)) &&
				(j >= SUB_W'(1)) && (j <= SUB_W'(3));
			MODE_BORDER: r = (i > SUB_W'(0)) && (i < SUB_W'(SCALE - 1)) &&
				(j > SUB_W'(0)) && (j < SUB_W'(SCALE - 1));
			MODE_DIAG:   r = (i == j) ||
				(({1'b0, i} + {1'b0, j}) == (SUB_W + 1)'(SCALE - 1));
			MODE_FULL:   r = 1'b1;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/dmdup_ifs.sv
// Channel interfaces of the pixel upscaler: source pixels, sub-pixel results, config writes.
// Depends on dmdup_pkg.
interface dmdup_pix_if;
	logic                          valid;
	logic                          ready;
	logic [dmdup_pkg::ZI_W-1:0]    zone_index;
	logic [dmdup_pkg::PIX_W-1:0]   pixel_data;
	modport source(output valid, zone_index, pixel_data, input ready);
	modport sink(input valid, zone_index, pixel_data, output ready);
endinterface

interface dmdup_sub_if;
	logic                          valid;
	logic                          ready;
	logic [dmdup_pkg::X_W-1:0]     screen_x;
	logic [dmdup_pkg::Y_W-1:0]     screen_y;
	logic [dmdup_pkg::COLOR_W-1:0] color565;
	logic                          block_last;
	logic                          zone_last;
	modport source(output valid, screen_x, screen_y, color565, block_last, zone_last,
		input ready);
	modport sink(input valid, screen_x, screen_y, color565, block_last, zone_last,
		output ready);
endinterface

interface dmdup_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [dmdup_pkg::CFG_IDX_W-1:0]  index;
	logic [dmdup_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/dmdup_front.sv
// Front end: takes source pixels, tracks column/row in the zone, builds expansion jobs.
// Depends on dmdup_pkg and dmdup_pix_if.
module dmdup_front #(
	parameter int ZONE_COLS    = dmdup_pkg::ZONE_COLS_DEF,
	parameter int ZONE_ROWS    = dmdup_pkg::ZONE_ROWS_DEF,
	parameter int ZONES_ACROSS = dmdup_pkg::ZONES_ACROSS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dmdup_pkg::cfg_t   cfg,
	dmdup_pix_if.sink         pix_in,
	output logic              push_valid,
	input  logic              push_ready,
	output dmdup_pkg::job_t   push_job
);
	import dmdup_pkg::*;

	localparam int COL_W = (ZONE_COLS > 1) ? $clog2(ZONE_COLS) : 1;
	localparam int ROW_W = (ZONE_ROWS > 1) ? $clog2(ZONE_ROWS) : 1;
	localparam int ZC_W  = (ZONES_ACROSS > 1) ? $clog2(ZONES_ACROSS) : 1;
	localparam int ZI_N  = 1 << ZI_W;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               v_s1;
	logic [X_W-1:0]     pos_x_s1;
	logic [Y_W-1:0]     pos_y_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               zend_s1;

	logic [ZC_W-1:0]    zcol_lut [ZI_N];
	logic [ZI_W-1:0]    zrow_lut [ZI_N];
	logic               in_take;
	logic               col_end;
	logic               row_end;

	// zone index split into column/row by constant tables
	for (genvar k = 0; k < ZI_N; k++) begin : g_zlut
		assign zcol_lut[k] = ZC_W'(k % ZONES_ACROSS);
		assign zrow_lut[k] = ZI_W'(k / ZONES_ACROSS);
	end

	assign pix_in.ready = !v_s1 || push_ready;
	assign in_take      = pix_in.valid && pix_in.ready;
	assign col_end      = (col_q == COL_W'(ZONE_COLS - 1));
	assign row_end      = (row_q == ROW_W'(ZONE_ROWS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (in_take) begin
				v_s1 <= 1'b1;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end else if (push_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pos_x_s1 <= X_W'(X_W'(zcol_lut[pix_in.zone_index]) * X_W'(ZONE_COLS)) +
				X_W'(col_q);
			pos_y_s1 <= Y_W'(Y_W'(zrow_lut[pix_in.zone_index]) * Y_W'(ZONE_ROWS)) +
				Y_W'(row_q);
			color_s1 <= to_rgb565(pix_in.pixel_data, cfg.fmt);
			zend_s1  <= col_end && row_end;
		end
	end

	assign push_valid        = v_s1;
	assign push_job.base_x   = X_W'(pos_x_s1 * X_W'(SCALE)) + cfg.x_off;
	assign push_job.base_y   = Y_W'(pos_y_s1 * Y_W'(SCALE)) + cfg.y_off;
	assign push_job.color    = color_s1;
	assign push_job.zone_end = zend_s1;

endmodule

// File: hdl/dmdup_fifo.sv
// Short job queue between front and back end.
// Depends on dmdup_pkg.
module dmdup_fifo #(
	parameter int DEPTH = dmdup_pkg::JOB_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  dmdup_pkg::job_t wr_job,
	output logic            rd_valid,
	input  logic            rd_ready,
	output dmdup_pkg::job_t rd_job
);
	import dmdup_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// File: hdl/dmdup_back.sv
// Back end: expands a job into a SCALE x SCALE run of sub-pixel words, one per cycle unless the sink stalls.
// Depends on dmdup_pkg and dmdup_sub_if.
module dmdup_back (
	input  logic            clk,
	input  logic            arst_n,
	input  dmdup_pkg::cfg_t cfg,
	input  logic            job_valid,
	output logic            job_ready,
	input  dmdup_pkg::job_t job,
	dmdup_sub_if.source     sub_out
);
	import dmdup_pkg::*;

	job_t               job_q;
	logic               active_q;
	logic [SUB_W-1:0]   i_q;
	logic [SUB_W-1:0]   j_q;
	logic               out_valid_q;
	logic [X_W-1:0]     x_q;
	logic [Y_W-1:0]     y_q;
	logic [COLOR_W-1:0] color_q;
	logic               blast_q;
	logic               zlast_q;
	logic               adv;
	logic               sub_end;
	logic               free;

	// one word emitted per cycle while the output register drains
	assign adv       = active_q && (!out_valid_q || sub_out.ready);
	assign sub_end   = (i_q == SUB_W'(SCALE - 1)) && (j_q == SUB_W'(SCALE - 1));
	assign free      = !active_q || (adv && sub_end);
	assign job_ready = free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (free) begin
				active_q <= job_valid;
			end
			if (adv) begin
				if (i_q == SUB_W'(SCALE - 1)) begin
					i_q <= '0;
					j_q <= sub_end ? '0 : j_q + SUB_W'(1);
				end else begin
					i_q <= i_q + SUB_W'(1);
				end
				out_valid_q <= 1'b1;
			end else if (sub_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free && job_valid) begin
			job_q <= job;
		end
		if (adv) begin
			x_q     <= job_q.base_x + X_W'(i_q);
			y_q     <= job_q.base_y + Y_W'(j_q);
			color_q <= sub_lit(cfg.mode, i_q, j_q) ? job_q.color : '0;
			blast_q <= sub_end;
			zlast_q <= sub_end && job_q.zone_end;
		end
	end

	assign sub_out.valid      = out_valid_q;
	assign sub_out.screen_x   = x_q;
	assign sub_out.screen_y   = y_q;
	assign sub_out.color565   = color_q;
	assign sub_out.block_last = blast_q;
	assign sub_out.zone_last  = zlast_q;

endmodule

// File: hdl/dmd_pixel_upscaler_with_mask_core.sv
// Pixel upscaler with dot mask: each source pixel becomes a 5x5 block of
// sub-pixel words with absolute screen coordinates and a masked RGB565 color.
// Words leave in row-major order, one per cycle while the sink is ready, so
// the sustained pixel rate is set by the back end's single output register.
// The front end keeps taking pixels while a block drains: it holds one pixel in
// its stage, the job queue holds JOB_DEPTH more, the back end one, and the
// output register may still hold the last word of the pixel before, so up to
// JOB_DEPTH + 3 pixels are in flight. The first word of a pixel that meets an
// idle block passes the front stage, job queue, back end job register
// and output register in turn. Column and row inside the zone are counted from
// the pixel stream itself and never restart on a zone index change. Config
// writes are taken any cycle but must only be issued while the block is idle.
// Depends on dmdup_pkg, dmdup_ifs, dmdup_front, dmdup_fifo, dmdup_back.
module dmd_pixel_upscaler_with_mask_core #(
	parameter int ZONE_COLS    = dmdup_pkg::ZONE_COLS_DEF,
	parameter int ZONE_ROWS    = dmdup_pkg::ZONE_ROWS_DEF,
	parameter int ZONES_ACROSS = dmdup_pkg::ZONES_ACROSS_DEF,
	parameter int JOB_DEPTH    = dmdup_pkg::JOB_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dmdup_pix_if.sink   pix_in,
	dmdup_sub_if.source sub_out,
	dmdup_cfg_if.sink   cfg
);
	import dmdup_pkg::*;

	mode_t          mode_q;
	fmt_t           fmt_q;
	logic [X_W-1:0] x_off_q;
	logic [Y_W-1:0] y_off_q;
	cfg_t           cfg_reg;

	logic           push_valid;
	logic           push_ready;
	job_t           push_job;
	logic           job_valid;
	logic           job_ready;
	job_t           job;

	// config registers; writes never stall
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_FULL;
			fmt_q   <= FMT_RGB888;
			x_off_q <= '0;
			y_off_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SCALING_MODE: mode_q  <= mode_t'(cfg.data[1:0]);
				REG_INPUT_FORMAT: fmt_q   <= fmt_t'(cfg.data[0]);
				REG_X_OFFSET:     x_off_q <= cfg.data[X_W-1:0];
				REG_Y_OFFSET:     y_off_q <= cfg.data[Y_W-1:0];
				default: ;  // unknown index: dropped
			endcase
		end
	end

	assign cfg_reg.mode  = mode_q;
	assign cfg_reg.fmt   = fmt_q;
	assign cfg_reg.x_off = x_off_q;
	assign cfg_reg.y_off = y_off_q;

	// front: counters, color conversion, base coordinates
	dmdup_front #(
		.ZONE_COLS   (ZONE_COLS),
		.ZONE_ROWS   (ZONE_ROWS),
		.ZONES_ACROSS(ZONES_ACROSS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_reg),
		.pix_in    (pix_in),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job)
	);

	// job queue decouples pixel intake from block expansion
	dmdup_fifo #(
		.DEPTH(JOB_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_job  (push_job),
		.rd_valid(job_valid),
		.rd_ready(job_ready),
		.rd_job  (job)
	);

	// back: 5x5 sweep with mask, registered output
	dmdup_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_reg),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job      (job),
		.sub_out  (sub_out)
	);

	// zone end only ever marks the last word of a block
	a_zone_last_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		sub_out.valid && sub_out.zone_last |-> sub_out.block_last)
		else $error("zone_last without block_last");

	// inside a block, words stream without bubbles once the sink takes one
	a_block_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		sub_out.valid && sub_out.ready && !sub_out.block_last |=> sub_out.valid)
		else $error("gap inside a sub-pixel block");

	// with no queued job, at most the last word of the old block is left
	a_job_pop: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready && !job_valid |=> !sub_out.valid || sub_out.block_last)
		else $error("output word without a job");

endmodule

// File: sim/dmd_pixel_upscaler_with_mask_core_test.sv
// Self-checking bench for the pixel upscaler core: directed rows, then random zone runs.
// Depends on dmdup_pkg, dmdup_ifs and the core RTL; needs no other file.
`timescale 1ns / 1ps

module dmd_pixel_upscaler_with_mask_core_test;
	import dmdup_pkg::*;

	// Geometry of the default build.
	localparam int ZONE_COLS    = ZONE_COLS_DEF;
	localparam int ZONE_ROWS    = ZONE_ROWS_DEF;
	localparam int ZONES_ACROSS = ZONES_ACROSS_DEF;
	localparam int ZONE_PIXELS  = ZONE_COLS * ZONE_ROWS;

	// Register indexes past the four real ones; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

	localparam int RAND_PHASES     = 4;
	localparam int PHASE_PIXELS    = 46;
	localparam int STEADY_PHASE    = 2;     // no idling on either side here
	localparam int IDLE_PCT        = 11;
	localparam int HOLD_AFTER      = 1000;  // words taken before the long sink hold
	localparam int HOLD_CYCLES     = 400;
	localparam int CFG_SETTLE      = 4;     // quiet cycles before a register write
	localparam int TAIL_CYCLES     = 30;
	localparam int CYCLE_LIMIT     = 200000;

	typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

	// One directed row: a pixel (sel = zone) or a register write (sel = index).
	// Where typed is set, the first word of the block is spelled out here.
	typedef struct {
		row_kind_t          kind;
		logic [7:0]         sel;
		logic [PIX_W-1:0]   val;
		bit                 typed;
		logic [X_W-1:0]     tx;
		logic [Y_W-1:0]     ty;
		logic [COLOR_W-1:0] tc;
	} plan_row_t;

	// One sub-pixel word as it leaves the core.
	typedef struct packed {
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [COLOR_W-1:0] color;
		logic               blk_last;
		logic               zn_last;
	} sub_word_t;

	logic clk = 1'b0;
	logic arst_n;

	dmdup_pix_if pix();
	dmdup_sub_if sub();
	dmdup_cfg_if cfg_ch();

	dmd_pixel_upscaler_with_mask_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix),
		.sub_out (sub),
		.cfg     (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bench copy of the register file and the zone counters.
	mode_t cur_mode;
	fmt_t  cur_fmt;
	logic [X_W-1:0] cur_x_off;
	logic [Y_W-1:0] cur_y_off;
	int src_col, src_row;

	sub_word_t subpix_due[$];   // words still owed by the core, oldest first
	plan_row_t plan[$];

	// Typed head word of the pixel on the bus; read by the monitor on acceptance.
	bit                 head_typed;
	logic [X_W-1:0]     head_x;
	logic [Y_W-1:0]     head_y;
	logic [COLOR_W-1:0] head_color;

	bit steady;                 // both sides stop idling while set
	int pixels_sent;
	int words_seen;
	int mismatches;
	int cycles;

	function automatic logic lit_at(input mode_t m, input int i, input int j);
		case (m)
			MODE_CENTER: return i >= 1 && i <= 3 && j >= 1 && j <= 3;
			MODE_BORDER: return i != 0 && i != SCALE - 1 && j != 0 && j != SCALE - 1;
			MODE_DIAG:   return i == j || i + j == SCALE - 1;
			default:     return 1'b1;
		endcase
	endfunction

	// Expand one accepted source pixel into its SCALE x SCALE words and step
	// the zone counters, exactly as the core is meant to.
	task automatic expand_pixel(input logic [ZI_W-1:0] zone, input logic [PIX_W-1:0] px);
		logic [COLOR_W-1:0] rgb;
		logic [4:0] red, blu;
		logic [5:0] grn;
		int zc, zr, x0, y0;
		bit zone_end;
		sub_word_t w;
		red = px[23:19];
		grn = px[15:10];
		blu = px[7:3];
		rgb = (cur_fmt == FMT_RGB565) ? px[15:0] : {red, grn, blu};
		zc = zone % ZONES_ACROSS;
		zr = zone / ZONES_ACROSS;
		x0 = (zc * ZONE_COLS + src_col) * SCALE + cur_x_off;
		y0 = (zr * ZONE_ROWS + src_row) * SCALE + cur_y_off;
		zone_end = src_col == ZONE_COLS - 1 && src_row == ZONE_ROWS - 1;
		for (int j = 0; j < SCALE; j++) begin
			for (int i = 0; i < SCALE; i++) begin
				w.x        = X_W'(x0 + i);
				w.y        = Y_W'(y0 + j);
				w.color    = lit_at(cur_mode, i, j) ? rgb : '0;
				w.blk_last = i == SCALE - 1 && j == SCALE - 1;
				w.zn_last  = w.blk_last && zone_end;
				// Hand-typed head word overrides the computed one.
				if (i == 0 && j == 0 && head_typed) begin
					w.x     = head_x;
					w.y     = head_y;
					w.color = head_color;
				end
				subpix_due.push_back(w);
			end
		end
		if (src_col >= ZONE_COLS - 1) begin
			src_col = 0;
			src_row = (src_row >= ZONE_ROWS - 1) ? 0 : src_row + 1;
		end else begin
			src_col++;
		end
	endtask

	// Monitor: everything is sampled at the rising edge.
	always @(posedge clk) begin : watch
		sub_word_t got, want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_SCALING_MODE: cur_mode  = mode_t'(cfg_ch.data[1:0]);
					REG_INPUT_FORMAT: cur_fmt   = fmt_t'(cfg_ch.data[0]);
					REG_X_OFFSET:     cur_x_off = cfg_ch.data[X_W-1:0];
					REG_Y_OFFSET:     cur_y_off = cfg_ch.data[Y_W-1:0];
					default: ;  // spare indexes change nothing
				endcase
			end
			if (pix.valid && pix.ready)
				expand_pixel(pix.zone_index, pix.pixel_data);
			if (sub.valid && sub.ready) begin
				got = {sub.screen_x, sub.screen_y, sub.color565, sub.block_last,
					sub.zone_last};
				words_seen++;
				if (subpix_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word x=%0d y=%0d c=%h bl=%b zl=%b",
							got.x, got.y, got.color, got.blk_last, got.zn_last);
				end else begin
					want = subpix_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("word %0d: exp x=%0d y=%0d c=%h bl=%b zl=%b, got x=%0d y=%0d c=%h bl=%b zl=%b",
								words_seen, want.x, want.y, want.color, want.blk_last,
								want.zn_last, got.x, got.y, got.color, got.blk_last,
								got.zn_last);
					end
				end
			end
		end
	end

	// Sink side: random back-pressure, plus one long hold once the stream is
	// well under way so the job queue fills and pix ready drops.
	initial begin : sink_side
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && words_seen >= HOLD_AFTER) begin
				held = 1'b1;
				sub.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			sub.ready <= steady || $urandom_range(99) >= IDLE_PCT;
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void add_row(input row_kind_t kind, input logic [7:0] sel,
		input logic [PIX_W-1:0] val, input bit typed, input logic [X_W-1:0] tx,
		input logic [Y_W-1:0] ty, input logic [COLOR_W-1:0] tc);
		plan_row_t r;
		r.kind  = kind;
		r.sel   = sel;
		r.val   = val;
		r.typed = typed;
		r.tx    = tx;
		r.ty    = ty;
		r.tc    = tc;
		plan.push_back(r);
	endfunction

	// Offer one pixel word, with random idle cycles ahead of it; returns at the
	// falling edge after it was taken, valid still high.
	task automatic send_pixel(input logic [ZI_W-1:0] zone, input logic [PIX_W-1:0] px,
		input bit typed, input logic [X_W-1:0] tx, input logic [Y_W-1:0] ty,
		input logic [COLOR_W-1:0] tc);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			pix.valid <= 1'b0;
			@(negedge clk);
		end
		pix.valid      <= 1'b1;
		pix.zone_index <= zone;
		pix.pixel_data <= px;
		head_typed = typed;
		head_x     = tx;
		head_y     = ty;
		head_color = tc;
		do @(posedge clk); while (!pix.ready);
		@(negedge clk);
		pixels_sent++;
	endtask

	// Register write: the core must be idle, so drain every owed word first.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		pix.valid <= 1'b0;
		while (subpix_due.size() != 0) @(negedge clk);
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [ZI_W-1:0]  zone;
		logic [PIX_W-1:0] px;

		pix.valid = 1'b0;
		pix.zone_index = '0;
		pix.pixel_data = '0;
		sub.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		head_typed = 1'b0;
		head_x = '0;
		head_y = '0;
		head_color = '0;
		steady = 1'b0;
		pixels_sent = 0;
		words_seen = 0;
		mismatches = 0;
		cur_mode = MODE_FULL;
		cur_fmt = FMT_RGB888;
		cur_x_off = '0;
		cur_y_off = '0;
		src_col = 0;
		src_row = 0;

		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Reset state: full mask, RGB888, no offsets, zone 0 column 0 onward.
		// Heads are typed for the pure primaries and the all-ones/all-zeros pixels.
		add_row(ROW_PIX, 8'd0, 24'hFFFFFF, 1, 10'd0,  8'd0, 16'hFFFF);
		add_row(ROW_PIX, 8'd0, 24'h000000, 1, 10'd5,  8'd0, 16'h0000);
		add_row(ROW_PIX, 8'd0, 24'hF80000, 1, 10'd10, 8'd0, 16'hF800);
		add_row(ROW_PIX, 8'd0, 24'h00FC00, 1, 10'd15, 8'd0, 16'h07E0);
		add_row(ROW_PIX, 8'd0, 24'h0000F8, 1, 10'd20, 8'd0, 16'h001F);
		// Each mask mode; zone index jumps mid-zone, counters keep going.
		add_row(ROW_CFG, REG_SCALING_MODE, PIX_W'(MODE_CENTER), 0, '0, '0, '0);
		add_row(ROW_PIX, 8'd63, 24'h123456, 0, '0, '0, '0);
		add_row(ROW_CFG, REG_SCALING_MODE, PIX_W'(MODE_BORDER), 0, '0, '0, '0);
		add_row(ROW_PIX, 8'd9, 24'hA5A5A5, 0, '0, '0, '0);
		add_row(ROW_CFG, REG_SCALING_MODE, PIX_W'(MODE_DIAG), 0, '0, '0, '0);
		add_row(ROW_PIX, 8'd9, 24'h5A5A5A, 0, '0, '0, '0);
		// RGB565 input: top byte must be ignored.
		add_row(ROW_CFG, REG_INPUT_FORMAT, PIX_W'(FMT_RGB565), 0, '0, '0, '0);
		add_row(ROW_PIX, 8'd9, 24'hFF0000, 0, '0, '0, '0);
		add_row(ROW_PIX, 8'd9, 24'h00ABCD, 0, '0, '0, '0);
		// Max offsets so coordinates wrap; upper data bits of narrow registers dropped.
		add_row(ROW_CFG, REG_X_OFFSET, 24'h3FF, 0, '0, '0, '0);
		add_row(ROW_CFG, REG_Y_OFFSET, 24'h3FF, 0, '0, '0, '0);
		add_row(ROW_CFG, REG_SCALING_MODE, {14'h0, 8'hFF, MODE_FULL}, 0, '0, '0, '0);
		add_row(ROW_PIX, 8'd63, 24'hFFFFFF, 0, '0, '0, '0);
		add_row(ROW_PIX, 8'd0, 24'h7FFFFF, 0, '0, '0, '0);
		// Writes to spare indexes go nowhere.
		add_row(ROW_CFG, REG_SPARE_LO, 24'h155, 0, '0, '0, '0);
		add_row(ROW_CFG, REG_SPARE_HI, 24'h3FF, 0, '0, '0, '0);
		add_row(ROW_PIX, 8'd7, 24'h800000, 0, '0, '0, '0);
		add_row(ROW_CFG, REG_INPUT_FORMAT, {15'h0, 8'hFF, FMT_RGB888}, 0, '0, '0, '0);
		add_row(ROW_PIX, 8'd56, 24'hC3C3C3, 0, '0, '0, '0);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG)
				cfg_write(plan[r].sel, plan[r].val[CFG_DATA_W-1:0]);
			else
				send_pixel(plan[r].sel[ZI_W-1:0], plan[r].val, plan[r].typed,
					plan[r].tx, plan[r].ty, plan[r].tc);
		end

		// Random phases: fresh register values each phase (written while drained,
		// which also gives the sender its full pause), then whole zones under one
		// index with the odd stray index change thrown in.
		zone = ZI_W'($urandom);
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			cfg_write(REG_SCALING_MODE, CFG_DATA_W'($urandom));
			cfg_write(REG_INPUT_FORMAT, CFG_DATA_W'($urandom));
			cfg_write(REG_X_OFFSET, CFG_DATA_W'($urandom));
			cfg_write(REG_Y_OFFSET, CFG_DATA_W'($urandom));
			steady = ph == STEADY_PHASE;
			for (int k = 0; k < PHASE_PIXELS; k++) begin
				if (pixels_sent % ZONE_PIXELS == 0 || $urandom_range(99) < 3)
					zone = ZI_W'($urandom);
				if ($urandom_range(7) == 0)
					px = $urandom_range(1) ? '1 : '0;
				else
					px = PIX_W'($urandom);
				send_pixel(zone, px, 1'b0, '0, '0, '0);
			end
			steady = 1'b0;
		end
		pix.valid <= 1'b0;

		// Drain, then give stray words a chance to show up.
		while (subpix_due.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatches == 0 && subpix_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: sim.f
hdl/dmdup_pkg.sv
hdl/dmdup_ifs.sv
hdl/dmdup_front.sv
hdl/dmdup_fifo.sv
hdl/dmdup_back.sv
hdl/dmd_pixel_upscaler_with_mask_core.sv
sim/dmd_pixel_upscaler_with_mask_core_test.sv
